@@ hw/rtl/mbrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrp_pkg
// shared constants, record types and helpers for the sector 0 parser
// ----------------------------------------------------------------------------
package mbrp_pkg;

	localparam int POS_W        = 9;
	localparam int SECTOR_LAST  = 511;
	localparam int SECTOR_BYTES = 512;
	localparam int TABLE_OFFSET = 446;
	localparam int TABLE_BYTES  = 64;
	localparam int TAB_AW       = 6;
	localparam int NAME_OFFSET  = 82;
	localparam int NAME_LEN     = 5;
	localparam int BPS_OFFSET   = 11;
	localparam int FAT16_OFFSET = 22;
	localparam int FAT32_OFFSET = 36;
	localparam int SIG_POS_LOW  = 510;

	localparam logic [7:0] SIG_LOW        = 8'h55;
	localparam logic [7:0] SIG_HIGH       = 8'hAA;
	localparam logic [7:0] TYPE_FAT32     = 8'h0B;
	localparam logic [7:0] TYPE_FAT32_LBA = 8'h0C;

	// byte offsets inside one 16-byte entry
	localparam logic [3:0] ENTRY_TYPE_OFF = 4'd4;
	localparam int ENTRY_START_BASE = 7;
	// reads per entry: type byte, four start bytes, four length bytes
	localparam logic [3:0] ENTRY_READS = 4'd9;

	typedef enum logic [1:0] {
		KIND_PARTITION     = 2'd0,
		KIND_RAW_FAT32     = 2'd1,
		KIND_NO_PARTITIONS = 2'd2,
		KIND_BAD_SIGNATURE = 2'd3
	} kind_t;

	typedef struct packed {
		logic sig_ok;
		logic raw;
	} finish_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  num;
		logic [31:0] start;
		logic [31:0] total;
		logic [7:0]  code;
		logic        fat32;
		logic        last;
	} record_t;

	function automatic logic [7:0] fat_name_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h46; // F
			3'd1:    c = 8'h41; // A
			3'd2:    c = 8'h54; // T
			3'd3:    c = 8'h33; // 3
			3'd4:    c = 8'h32; // 2
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mbrp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mbrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/mbrp_capture.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrp_capture
// byte position tracking, boot-sector field capture and table ram writes
// ----------------------------------------------------------------------------
module mbrp_capture
	import mbrp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic [7:0]        data_byte,
	input  wire logic              start_of_sector,
	output logic                   wr_en,
	output logic [TAB_AW-1:0]      wr_addr,
	output logic [7:0]             wr_data,
	output logic                   fin_valid,
	output finish_t                fin
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos;
	logic             name_q;
	logic [15:0]      bps_q;
	logic [15:0]      f16_q;
	logic             large_q;
	logic             sig_low_q;

	logic             in_name;
	logic             in_large;
	logic             in_tab;
	logic [2:0]       name_idx;

	assign pos      = start_of_sector ? '0 : pos_q;
	assign in_name  = (pos >= POS_W'(NAME_OFFSET)) && (pos < POS_W'(NAME_OFFSET + NAME_LEN));
	assign in_large = (pos >= POS_W'(FAT32_OFFSET)) && (pos < POS_W'(FAT32_OFFSET + 4));
	assign in_tab   = (pos >= POS_W'(TABLE_OFFSET)) && (pos < POS_W'(TABLE_OFFSET + TABLE_BYTES));
	assign name_idx = 3'(pos - POS_W'(NAME_OFFSET));

	assign wr_en   = in_fire && in_tab;
	assign wr_addr = TAB_AW'(pos - POS_W'(TABLE_OFFSET));
	assign wr_data = data_byte;

	assign fin_valid  = in_fire && (pos == POS_W'(SECTOR_LAST));
	assign fin.sig_ok = sig_low_q && (data_byte == SIG_HIGH);
	assign fin.raw    = name_q ||
		((bps_q == 16'(SECTOR_BYTES)) && (f16_q == 16'd0) && large_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			name_q    <= 1'b1;
			bps_q     <= '0;
			f16_q     <= '0;
			large_q   <= 1'b0;
			sig_low_q <= 1'b0;
		end else if (in_fire) begin
			pos_q <= pos + 1'b1;
			if (pos == '0) begin
				name_q    <= 1'b1;
				large_q   <= 1'b0;
				sig_low_q <= 1'b0;
			end
			if (in_name && (data_byte != fat_name_char(name_idx))) begin
				name_q <= 1'b0;
			end
			if (pos == POS_W'(BPS_OFFSET))       bps_q[7:0]  <= data_byte;
			if (pos == POS_W'(BPS_OFFSET + 1))   bps_q[15:8] <= data_byte;
			if (pos == POS_W'(FAT16_OFFSET))     f16_q[7:0]  <= data_byte;
			if (pos == POS_W'(FAT16_OFFSET + 1)) f16_q[15:8] <= data_byte;
			if (in_large && (data_byte != 8'd0)) begin
				large_q <= 1'b1;
			end
			if (pos == POS_W'(SIG_POS_LOW)) begin
				sig_low_q <= (data_byte == SIG_LOW);
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/mbrp_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrp_emit
// walks the table ram entry by entry and emits one record per valid entry, or one status record
// ----------------------------------------------------------------------------
module mbrp_emit
	import mbrp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fin_valid,
	input  wire finish_t           fin,
	input  wire logic [31:0]       disk_total,
	output logic                   rd_en,
	output logic [TAB_AW-1:0]      rd_addr,
	input  wire logic [7:0]        rd_data,
	output logic                   busy,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output record_t                out_rec
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_FINAL
	} state_t;

	state_t      state_q;
	logic [1:0]  ent_q;
	logic [3:0]  k_q;
	logic [7:0]  cur_type_q;
	logic [31:0] cur_start_q;
	logic [31:0] cur_len_q;
	logic        pend_q;
	logic [2:0]  pend_num_q;
	logic [7:0]  pend_type_q;
	logic [31:0] pend_start_q;
	logic [31:0] pend_len_q;
	logic [2:0]  cnt_q;
	kind_t       fin_kind_q;
	logic        out_valid_q;
	record_t     out_q;

	logic        out_free;
	logic        cur_ok;
	logic [3:0]  off;
	logic [3:0]  j;
	record_t     pend_rec;

	assign out_free  = !out_valid_q || out_ready;
	assign cur_ok    = (cur_type_q != 8'd0) && (cur_len_q != 32'd0) &&
		(cur_start_q < disk_total);
	assign off       = (k_q == 4'd0) ? ENTRY_TYPE_OFF : 4'(k_q + 4'(ENTRY_START_BASE));
	assign j         = k_q - 4'd1;
	assign rd_en     = (state_q == ST_READ) && (k_q != ENTRY_READS);
	assign rd_addr   = {ent_q, off};
	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_rec   = out_q;

	always_comb begin
		pend_rec.kind  = KIND_PARTITION;
		pend_rec.num   = pend_num_q;
		pend_rec.start = pend_start_q;
		pend_rec.total = pend_len_q;
		pend_rec.code  = pend_type_q;
		pend_rec.fat32 = (pend_type_q == TYPE_FAT32) || (pend_type_q == TYPE_FAT32_LBA);
		pend_rec.last  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ent_q       <= '0;
			k_q         <= '0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			fin_kind_q  <= KIND_NO_PARTITIONS;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (fin_valid) begin
						ent_q  <= '0;
						k_q    <= '0;
						pend_q <= 1'b0;
						cnt_q  <= '0;
						if (!fin.sig_ok) begin
							fin_kind_q <= KIND_BAD_SIGNATURE;
							state_q    <= ST_FINAL;
						end else begin
							fin_kind_q <= fin.raw ? KIND_RAW_FAT32 : KIND_NO_PARTITIONS;
							state_q    <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// data of the previous address lands now
					if (k_q != 4'd0) begin
						if (j == 4'd0) begin
							cur_type_q <= rd_data;
						end else if (j < 4'd5) begin
							cur_start_q <= {rd_data, cur_start_q[31:8]};
						end else begin
							cur_len_q <= {rd_data, cur_len_q[31:8]};
						end
					end
					if (k_q == ENTRY_READS) begin
						state_q <= ST_CHECK;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				ST_CHECK: begin
					if (!cur_ok || !pend_q || out_free) begin
						if (cur_ok) begin
							// hold the newest valid entry until its successor is known
							if (pend_q) begin
								out_q       <= pend_rec;
								out_valid_q <= 1'b1;
							end
							pend_q       <= 1'b1;
							pend_num_q   <= cnt_q + 3'd1;
							pend_type_q  <= cur_type_q;
							pend_start_q <= cur_start_q;
							pend_len_q   <= cur_len_q;
							cnt_q        <= cnt_q + 3'd1;
						end
						if (ent_q == 2'd3) begin
							state_q <= ST_FINAL;
						end else begin
							ent_q   <= ent_q + 2'd1;
							k_q     <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						if (pend_q) begin
							out_q      <= pend_rec;
							out_q.last <= 1'b1;
						end else begin
							out_q.kind  <= fin_kind_q;
							out_q.num   <= '0;
							out_q.start <= '0;
							out_q.total <= '0;
							out_q.code  <= '0;
							out_q.fat32 <= 1'b0;
							out_q.last  <= 1'b1;
						end
						out_valid_q <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/mbr_sector_partition_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_sector_partition_parser_unit
// parses sector 0 of a disk into partition records
// ----------------------------------------------------------------------------
// usage
// - s_* stream carries the sector, one byte per transfer; tuser marks byte 0
//   of a new sector and drops any partial sector
// - cfg_* channel writes the disk size in sectors, always ready; write it
//   only while the block is idle
// - m_* stream gives one record per valid table entry, or a single raw
//   fat32 / no partitions / bad signature record; tlast ends the sector
// - bytes are taken at one per cycle while s_tready is high; the table bytes go into a 64-byte ram
// - after byte 511 s_tready drops while the sequencer reads nine bytes of
//   each entry and checks it, then hands over the final record; a bad
//   signature goes straight to the final record, and a stalled receiver
//   holds the check and the final record
// - the last record of a sector leaves from the output register, so the next
//   sector can start streaming while it still waits for m_tready
// - reset initialises position, capture flags, sequencer and output valid; the
//   disk size resets to zero, which makes every entry invalid
// ----------------------------------------------------------------------------
module mbr_sector_partition_parser_unit
	import mbrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_tuser,   // [0] start_of_sector
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,  // disk_total_sectors
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [2:0] partition_number, [34:3] first_sector,
	                                    // [66:35] sector_total, [74:67] type_code,
	                                    // [79:75] zero
	output logic [2:0]       m_tuser,   // [1:0] record_kind, [2] fat32_type
	output logic             m_tlast    // last_record
);

	logic [31:0]     disk_q;
	logic            busy;
	logic            in_fire;
	logic            wr_en;
	logic [TAB_AW-1:0] wr_addr;
	logic [7:0]      wr_data;
	logic            rd_en;
	logic [TAB_AW-1:0] rd_addr;
	logic [7:0]      rd_data;
	logic            fin_valid;
	finish_t         fin;
	record_t         rec;

	// input stalls only while the table walk runs
	assign s_tready  = !busy;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q <= '0;
		end else if (cfg_valid) begin
			disk_q <= cfg_data;
		end
	end

	mbrp_capture u_capture (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_fire),
		.data_byte       (s_tdata),
		.start_of_sector (s_tuser[0]),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.fin_valid       (fin_valid),
		.fin             (fin)
	);

	// raw copy of the partition table, bytes 446 to 509
	mbrp_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_BYTES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mbrp_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.fin_valid  (fin_valid),
		.fin        (fin),
		.disk_total (disk_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.busy       (busy),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_rec    (rec)
	);

	assign m_tdata = {5'd0, rec.code, rec.total, rec.start, rec.num};
	assign m_tuser = {rec.fat32, rec.kind};
	assign m_tlast = rec.last;

endmodule
`default_nettype wire
